/* sv/cbq_pkg.sv */
package cbq_pkg;

   localparam int COEF_WIDTH     = 18;
   localparam int NUM_REGS       = 7;
   localparam int REG_IDX_WIDTH  = 3;
   localparam int MEM_DEPTH      = 8;

   localparam logic [REG_IDX_WIDTH-1:0] REG_B0  = 3'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_B1  = 3'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_B2  = 3'd2;
   localparam logic [REG_IDX_WIDTH-1:0] REG_FA1 = 3'd3;
   localparam logic [REG_IDX_WIDTH-1:0] REG_FA2 = 3'd4;
   localparam logic [REG_IDX_WIDTH-1:0] REG_SA1 = 3'd5;
   localparam logic [REG_IDX_WIDTH-1:0] REG_SA2 = 3'd6;

   localparam logic signed [COEF_WIDTH-1:0] COEF_RESET [NUM_REGS] = '{
      18'sd58642, -18'sd117290, 18'sd58642,
      -18'sd116563, 18'sd52488,
      -18'sd115160, 18'sd39571
   };

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } cbq_state_type;

endpackage

/* sv/cbq_ram.sv */
module cbq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/cascaded_biquad_iir_filter_core.sv */
// one transaction at a time: req_ready stays low until the result is taken into the output register;
// a single shared multiply-accumulate does ten products over two sections of seven steps
// reset: synchronous, clears control, valid bits of the delay-line ram
// (so all filter history reads as zero) and loads default coefficients
module cascaded_biquad_iir_filter_core
   import cbq_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int STATE_WIDTH    = 24,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   input  logic                           req_block_end,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                           rsp_block_end_out,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [REG_IDX_WIDTH-1:0]       csr_index,
   input  logic signed [COEF_WIDTH-1:0]   csr_wdata
);

   localparam int PROD_WIDTH = STATE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + 3;
   localparam int ADDR_WIDTH = $clog2(MEM_DEPTH);
   localparam logic signed [ACC_WIDTH-1:0] ROUND_CONST =
      ACC_WIDTH'(1) <<< (COEF_FRAC_BITS - 1);

   localparam logic [2:0] STEP_B0  = 3'd0;
   localparam logic [2:0] STEP_B1  = 3'd1;
   localparam logic [2:0] STEP_B2  = 3'd2;
   localparam logic [2:0] STEP_A1  = 3'd3;
   localparam logic [2:0] STEP_A2  = 3'd4;
   localparam logic [2:0] STEP_SUM = 3'd5;
   localparam logic [2:0] STEP_OUT = 3'd6;

   localparam logic [1:0] SLOT_X1 = 2'd0;
   localparam logic [1:0] SLOT_X2 = 2'd1;
   localparam logic [1:0] SLOT_Y1 = 2'd2;
   localparam logic [1:0] SLOT_Y2 = 2'd3;

   cbq_state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic       sect_ff, sect_in;

   logic signed [COEF_WIDTH-1:0]  coef_ff [NUM_REGS];
   logic signed [STATE_WIDTH-1:0] cur_x_ff, cur_x_in;
   logic signed [STATE_WIDTH-1:0] old_ff, old_in;
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic                          prod_vld_ff, prod_vld_in;
   logic                          prod_sub_ff, prod_sub_in;
   logic signed [ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic                          mark_ff, mark_in;
   logic [MEM_DEPTH-1:0]          valid_ff;
   logic                          rd_vld_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic                          rsp_mark_ff, rsp_mark_in;

   logic                          rd_en, wr_en;
   logic [1:0]                    rd_slot, wr_slot;
   logic [ADDR_WIDTH-1:0]         rd_addr, wr_addr;
   logic [STATE_WIDTH-1:0]        rd_data;
   logic signed [STATE_WIDTH-1:0] wr_data;
   logic signed [STATE_WIDTH-1:0] rd_op;
   logic [REG_IDX_WIDTH-1:0]      coef_sel;
   logic signed [COEF_WIDTH-1:0]  mul_a;
   logic signed [STATE_WIDTH-1:0] mul_b;
   logic signed [ACC_WIDTH-1:0]   acc_shift;
   logic signed [STATE_WIDTH-1:0] sect_y;
   logic signed [SAMPLE_WIDTH-1:0] out_sat;
   logic [ACC_WIDTH-STATE_WIDTH:0] acc_hi;
   logic [STATE_WIDTH-SAMPLE_WIDTH:0] y_hi;
   logic                          out_free;
   logic                          accept;

   assign rd_addr = {sect_ff, rd_slot};
   assign wr_addr = {sect_ff, wr_slot};
   assign rd_op   = rd_vld_ff ? $signed(rd_data) : '0;
   assign mul_a   = coef_ff[coef_sel];
   assign prod_in = mul_a * mul_b;

   // round half up, floor shift, saturate to the section width
   assign acc_shift = acc_ff >>> COEF_FRAC_BITS;
   assign acc_hi    = acc_shift[ACC_WIDTH-1:STATE_WIDTH-1];
   always_comb begin
      if ((&acc_hi) || !(|acc_hi)) begin
         sect_y = acc_shift[STATE_WIDTH-1:0];
      end else begin
         sect_y = {acc_hi[ACC_WIDTH-STATE_WIDTH],
                   {(STATE_WIDTH-1){~acc_hi[ACC_WIDTH-STATE_WIDTH]}}};
      end
   end

   assign y_hi = sect_y[STATE_WIDTH-1:SAMPLE_WIDTH-1];
   always_comb begin
      if ((&y_hi) || !(|y_hi)) begin
         out_sat = sect_y[SAMPLE_WIDTH-1:0];
      end else begin
         out_sat = {y_hi[STATE_WIDTH-SAMPLE_WIDTH],
                    {(SAMPLE_WIDTH-1){~y_hi[STATE_WIDTH-SAMPLE_WIDTH]}}};
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      sect_in       = sect_ff;
      cur_x_in      = cur_x_ff;
      old_in        = old_ff;
      mark_in       = mark_ff;
      prod_vld_in   = 1'b0;
      prod_sub_in   = 1'b0;
      acc_in        = prod_vld_ff ? (prod_sub_ff ? acc_ff - ACC_WIDTH'(prod_ff)
                                                 : acc_ff + ACC_WIDTH'(prod_ff))
                                  : acc_ff;
      rd_en         = 1'b0;
      rd_slot       = SLOT_X1;
      wr_en         = 1'b0;
      wr_slot       = SLOT_X1;
      wr_data       = old_ff;
      coef_sel      = REG_B0;
      mul_b         = rd_op;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_mark_in   = rsp_mark_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               step_in  = STEP_B0;
               sect_in  = 1'b0;
               cur_x_in = STATE_WIDTH'(req_sample_in);
               mark_in  = req_block_end;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 3'd1;
            unique case (step_ff)
               STEP_B0: begin
                  rd_en       = 1'b1;
                  rd_slot     = SLOT_X1;
                  coef_sel    = REG_B0;
                  mul_b       = cur_x_ff;
                  prod_vld_in = 1'b1;
                  acc_in      = ROUND_CONST;
               end
               STEP_B1: begin
                  rd_en       = 1'b1;
                  rd_slot     = SLOT_X2;
                  coef_sel    = REG_B1;
                  prod_vld_in = 1'b1;
                  old_in      = rd_op;
               end
               STEP_B2: begin
                  rd_en       = 1'b1;
                  rd_slot     = SLOT_Y1;
                  coef_sel    = REG_B2;
                  prod_vld_in = 1'b1;
                  wr_en       = 1'b1;
                  wr_slot     = SLOT_X2;
                  wr_data     = old_ff;
               end
               STEP_A1: begin
                  rd_en       = 1'b1;
                  rd_slot     = SLOT_Y2;
                  coef_sel    = sect_ff ? REG_SA1 : REG_FA1;
                  prod_vld_in = 1'b1;
                  prod_sub_in = 1'b1;
                  old_in      = rd_op;
                  wr_en       = 1'b1;
                  wr_slot     = SLOT_X1;
                  wr_data     = cur_x_ff;
               end
               STEP_A2: begin
                  coef_sel    = sect_ff ? REG_SA2 : REG_FA2;
                  prod_vld_in = 1'b1;
                  prod_sub_in = 1'b1;
                  wr_en       = 1'b1;
                  wr_slot     = SLOT_Y2;
                  wr_data     = old_ff;
               end
               STEP_SUM: begin
               end
               STEP_OUT: begin
                  wr_slot = SLOT_Y1;
                  wr_data = sect_y;
                  if (!sect_ff) begin
                     wr_en    = 1'b1;
                     cur_x_in = sect_y;
                     sect_in  = 1'b1;
                     step_in  = STEP_B0;
                  end else if (out_free) begin
                     wr_en         = 1'b1;
                     state_in      = ST_IDLE;
                     step_in       = STEP_B0;
                     rsp_valid_in  = 1'b1;
                     rsp_sample_in = out_sat;
                     rsp_mark_in   = mark_ff;
                  end else begin
                     step_in = step_ff;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
                  step_in  = STEP_B0;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_B0;
         sect_ff      <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sect_ff      <= sect_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff      <= cur_x_in;
      old_ff        <= old_in;
      mark_ff       <= mark_in;
      prod_ff       <= prod_in;
      prod_sub_ff   <= prod_sub_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_mark_ff   <= rsp_mark_in;
   end

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            coef_ff[i] <= COEF_RESET[i];
         end
      end else if (csr_valid && csr_ready &&
                   (csr_index < REG_IDX_WIDTH'(NUM_REGS))) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   cbq_ram #(
      .WIDTH (STATE_WIDTH),
      .DEPTH (MEM_DEPTH)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_block_end_out = rsp_mark_ff;

endmodule

/* sv/cbq_checker.sv */
module cbq_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   input logic                           rsp_block_end_out
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_sample_out) && $stable(rsp_block_end_out))
      else $error("response changed while stalled");

   // busy right after a transaction is taken
   a_busy_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_busy_two: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 !req_ready)
      else $error("sequencer finished too early");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind cascaded_biquad_iir_filter_core cbq_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_cbq_checker (.*);

/* tb/sv/cascaded_biquad_iir_filter_core_tb.sv */
`timescale 1ns / 100ps

module cascaded_biquad_iir_filter_core_tb
   import cbq_pkg::*;
();

   localparam int SAMPLE_W     = 16;
   localparam int STATE_W      = 24;
   localparam int FRAC_BITS    = 16;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int MAX_PRINTS   = 100;

   localparam logic [REG_IDX_WIDTH-1:0] REG_UNUSED = 3'd7;

   localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = 18'sd131071;
   localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = -18'sd131072;
   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = 18'sd65536;

   localparam logic signed [SAMPLE_W-1:0] DIRECTED_SAMPLES [20] = '{
      16'sd0, 16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
      -16'sd32768, 16'sd0, -16'sd1, 16'sd1, 16'sd32767, -16'sd32768,
      16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd21845,
      -16'sd21846, 16'sd0, 16'sd0
   };

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       mark;
   } sample_item_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_W-1:0]    req_sample_in = '0;
   logic                          req_block_end = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0]    rsp_sample_out;
   logic                          rsp_block_end_out;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [REG_IDX_WIDTH-1:0]      csr_index = '0;
   logic signed [COEF_WIDTH-1:0]  csr_wdata = '0;

   sample_item_type pending_samples [$];
   sample_item_type expected_outputs [$];
   sample_item_type received_want;

   longint coef [NUM_REGS] = '{58642, -117290, 58642, -116563, 52488, -115160, 39571};
   longint sec1_x [2] = '{0, 0};
   longint sec1_y [2] = '{0, 0};
   longint sec2_x [2] = '{0, 0};
   longint sec2_y [2] = '{0, 0};

   int     mismatch_cnt = 0;
   int     accepted_cnt = 0;
   int     hold_left = 0;
   bit     hold_done = 1'b0;
   bit     no_idle = 1'b0;
   longint walk_level = 0;

   cascaded_biquad_iir_filter_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_in     (req_sample_in),
      .req_block_end     (req_block_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_block_end_out (rsp_block_end_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint saturate(input longint v, input int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic longint biquad_section(input longint x0, input longint x1,
                                             input longint x2, input longint y1,
                                             input longint y2, input longint a1,
                                             input longint a2);
      longint acc;
      acc = coef[REG_B0] * x0 + coef[REG_B1] * x1 + coef[REG_B2] * x2
          - a1 * y1 - a2 * y2 + (longint'(1) <<< (FRAC_BITS - 1));
      return saturate(acc >>> FRAC_BITS, STATE_W);
   endfunction

   // two cascaded sections, delay lines updated in place
   function automatic logic signed [SAMPLE_W-1:0] predict_filter(
      input logic signed [SAMPLE_W-1:0] x_in);
      longint x;
      longint s1;
      longint s2;
      longint o;
      x = x_in;
      s1 = biquad_section(x, sec1_x[0], sec1_x[1], sec1_y[0], sec1_y[1],
                          coef[REG_FA1], coef[REG_FA2]);
      sec1_x[1] = sec1_x[0];
      sec1_x[0] = x;
      sec1_y[1] = sec1_y[0];
      sec1_y[0] = s1;
      s2 = biquad_section(s1, sec2_x[0], sec2_x[1], sec2_y[0], sec2_y[1],
                          coef[REG_SA1], coef[REG_SA2]);
      sec2_x[1] = sec2_x[0];
      sec2_x[0] = s1;
      sec2_y[1] = sec2_y[0];
      sec2_y[0] = s2;
      o = saturate(s2, SAMPLE_W);
      return o[SAMPLE_W-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_cnt < MAX_PRINTS) $display("mismatch at %0t: %s", $time, msg);
      mismatch_cnt++;
   endtask

   task automatic push_item(input logic signed [SAMPLE_W-1:0] s, input logic m);
      sample_item_type it;
      it.sample = s;
      it.mark = m;
      pending_samples.push_back(it);
   endtask

   // mix of full-range noise, small values, rails and a random walk
   task automatic push_random(input int n);
      int k;
      int style;
      logic signed [SAMPLE_W-1:0] s;
      for (k = 0; k < n; k++) begin
         style = $urandom_range(99);
         if (style < 35) begin
            s = SAMPLE_W'($urandom_range(0, 65535));
         end else if (style < 50) begin
            s = SAMPLE_W'($urandom_range(0, 2000) - 1000);
         end else if (style < 60) begin
            case ($urandom_range(3))
               0: s = 16'sd32767;
               1: s = -16'sd32768;
               2: s = 16'sd0;
               default: s = -16'sd1;
            endcase
         end else begin
            walk_level = saturate(walk_level + $urandom_range(0, 6000) - 3000, SAMPLE_W);
            s = walk_level[SAMPLE_W-1:0];
         end
         push_item(s, $urandom_range(15) == 0);
      end
   endtask

   task automatic push_rails(input int n);
      int k;
      for (k = 0; k < n; k++) begin
         push_item(k[0] ? -16'sd32768 : 16'sd32767, k == n - 1);
      end
   endtask

   // leaves csr_valid high so back-to-back writes need no toggle
   task automatic write_reg(input logic [REG_IDX_WIDTH-1:0] idx,
                            input logic signed [COEF_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx < NUM_REGS) coef[idx] = value;
   endtask

   task automatic write_all(input logic signed [COEF_WIDTH-1:0] value);
      write_reg(REG_B0, value);
      write_reg(REG_B1, value);
      write_reg(REG_B2, value);
      write_reg(REG_FA1, value);
      write_reg(REG_FA2, value);
      write_reg(REG_SA1, value);
      write_reg(REG_SA2, value);
      csr_valid <= 1'b0;
   endtask

   task automatic write_defaults();
      write_reg(REG_B0, 18'sd58642);
      write_reg(REG_B1, -18'sd117290);
      write_reg(REG_B2, 18'sd58642);
      write_reg(REG_FA1, -18'sd116563);
      write_reg(REG_FA2, 18'sd52488);
      write_reg(REG_SA1, -18'sd115160);
      write_reg(REG_SA2, 18'sd39571);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_valid || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic offer_next();
      sample_item_type it;
      if (pending_samples.size() != 0 && (no_idle || $urandom_range(99) >= 8)) begin
         it = pending_samples.pop_front();
         req_valid <= 1'b1;
         req_sample_in <= it.sample;
         req_block_end <= it.mark;
      end else begin
         req_valid <= 1'b0;
      end
   endtask

   // driver
   always @(posedge clock) begin
      sample_item_type exp_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_ready) begin
         exp_item.sample = predict_filter(req_sample_in);
         exp_item.mark = req_block_end;
         expected_outputs.push_back(exp_item);
         accepted_cnt++;
         offer_next();
      end else if (!req_valid) begin
         offer_next();
      end
   end

   // monitor and receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_outputs.size() == 0) begin
               report_mismatch("result with no transaction outstanding");
            end else begin
               received_want = expected_outputs.pop_front();
               if (rsp_sample_out !== received_want.sample)
                  report_mismatch($sformatf("sample_out got %0d want %0d",
                                            rsp_sample_out, received_want.sample));
               if (rsp_block_end_out !== received_want.mark)
                  report_mismatch($sformatf("block_end_out got %0b want %0b",
                                            rsp_block_end_out, received_want.mark));
            end
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 8);
         end
      end
   end

   initial begin
      int k;
      int r;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients, directed then random
      for (k = 0; k < 20; k++) push_item(DIRECTED_SAMPLES[k], (k % 7) == 6);
      push_random(500);
      wait_idle();

      // unstable extremes drive both sections into saturation
      write_all(COEF_MAX);
      push_rails(10);
      push_random(30);
      wait_idle();

      write_all(COEF_MIN);
      push_rails(10);
      push_random(30);
      wait_idle();

      // pass-through, plus a write to an unmapped index that must be dropped
      write_all(18'sd0);
      @(posedge clock);
      write_reg(REG_B0, COEF_ONE);
      write_reg(REG_UNUSED, COEF_MAX);
      csr_valid <= 1'b0;
      push_random(100);
      wait_idle();

      // back to defaults with no idling on either side
      write_defaults();
      no_idle = 1'b1;
      push_random(600);
      wait_idle();
      no_idle = 1'b0;

      for (r = 0; r < 3; r++) begin
         write_reg(REG_B0, COEF_WIDTH'($urandom_range(0, 262143)));
         write_reg(REG_B1, COEF_WIDTH'($urandom_range(0, 262143)));
         write_reg(REG_B2, COEF_WIDTH'($urandom_range(0, 262143)));
         write_reg(REG_FA1, COEF_WIDTH'($urandom_range(0, 262143)));
         write_reg(REG_FA2, COEF_WIDTH'($urandom_range(0, 262143)));
         write_reg(REG_SA1, COEF_WIDTH'($urandom_range(0, 262143)));
         write_reg(REG_SA2, COEF_WIDTH'($urandom_range(0, 262143)));
         write_reg(REG_UNUSED, COEF_WIDTH'($urandom_range(0, 262143)));
         csr_valid <= 1'b0;
         push_random(150);
         wait_idle();
      end

      write_defaults();
      push_random(200);
      wait_idle();

      if (mismatch_cnt == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* files.f */
sv/cbq_pkg.sv
sv/cbq_ram.sv
sv/cascaded_biquad_iir_filter_core.sv
sv/cbq_checker.sv
tb/sv/cascaded_biquad_iir_filter_core_tb.sv
